// ----- src/pis_pkg.sv -----
// Package for the partial insertion sort block: field widths, reset constants,
// controller state type and the command and status bundles. No dependencies.
`default_nettype none

package pis_pkg;

  localparam int CODE_W      = 16;
  localparam int SCORE_W     = 16;
  localparam int WORD_W      = CODE_W + SCORE_W;
  localparam int MAX_ENTRIES = 64;

  localparam logic signed [SCORE_W-1:0] THRESHOLD_RESET = 16'sd200;

  typedef enum logic [3:0] {
    S_COLLECT,
    S_RD_I,
    S_EVAL_I,
    S_MOVE,
    S_SHIFT,
    S_PLACE,
    S_EMIT_RD,
    S_EMIT_LOAD,
    S_EMIT_HOLD
  } state_t;

  typedef struct packed {
    logic collect;
    logic rd_i;
    logic eval_i;
    logic move;
    logic shift;
    logic place;
    logic emit_rd;
    logic emit_load;
    logic emit_hold;
  } cmd_t;

  typedef struct packed {
    logic last_fire;
    logic multi;
    logic hit;
    logic less;
    logic j_one;
    logic i_end;
    logic out_fire;
    logic k_end;
  } status_t;

endpackage

`default_nettype wire

// ----- src/pis_if.sv -----
// Channel interfaces of the partial insertion sort block: input items,
// result items and the threshold write channel. Depends on pis_pkg.
`default_nettype none

interface pis_entry_if;
  logic                                valid;
  logic                                ready;
  logic [pis_pkg::CODE_W-1:0]          move_code;
  logic signed [pis_pkg::SCORE_W-1:0]  score;
  logic                                last_entry;

  modport source (output valid, move_code, score, last_entry, input ready);
  modport sink   (input valid, move_code, score, last_entry, output ready);
endinterface

interface pis_result_if;
  logic                                valid;
  logic                                ready;
  logic [pis_pkg::CODE_W-1:0]          out_move_code;
  logic signed [pis_pkg::SCORE_W-1:0]  out_score;
  logic                                out_last;
  logic                                overflowed;

  modport source (output valid, out_move_code, out_score, out_last, overflowed, input ready);
  modport sink   (input valid, out_move_code, out_score, out_last, overflowed, output ready);
endinterface

interface pis_cfg_if;
  logic                                valid;
  logic                                ready;
  logic signed [pis_pkg::SCORE_W-1:0]  score_threshold;

  modport source (output valid, score_threshold, input ready);
  modport sink   (input valid, score_threshold, output ready);
endinterface

`default_nettype wire

// ----- src/pis_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/pis_ctrl.sv -----
// Controller of the partial insertion sort block: sequences collection,
// the insertion passes and result output. Depends on pis_pkg.
`default_nettype none

module pis_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pis_pkg::status_t status,
  output pis_pkg::cmd_t         cmd
);

  pis_pkg::state_t state;
  pis_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pis_pkg::S_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pis_pkg::S_COLLECT: begin
        if (status.last_fire) begin
          state_next = status.multi ? pis_pkg::S_RD_I : pis_pkg::S_EMIT_RD;
        end
      end
      pis_pkg::S_RD_I: begin
        state_next = pis_pkg::S_EVAL_I;
      end
      pis_pkg::S_EVAL_I: begin
        if (status.hit) begin
          state_next = pis_pkg::S_MOVE;
        end else if (status.i_end) begin
          state_next = pis_pkg::S_EMIT_RD;
        end else begin
          state_next = pis_pkg::S_RD_I;
        end
      end
      pis_pkg::S_MOVE: begin
        state_next = pis_pkg::S_SHIFT;
      end
      pis_pkg::S_SHIFT: begin
        if (status.less) begin
          state_next = status.j_one ? pis_pkg::S_PLACE : pis_pkg::S_SHIFT;
        end else if (status.i_end) begin
          state_next = pis_pkg::S_EMIT_RD;
        end else begin
          state_next = pis_pkg::S_RD_I;
        end
      end
      pis_pkg::S_PLACE: begin
        state_next = status.i_end ? pis_pkg::S_EMIT_RD : pis_pkg::S_RD_I;
      end
      pis_pkg::S_EMIT_RD: begin
        state_next = pis_pkg::S_EMIT_LOAD;
      end
      pis_pkg::S_EMIT_LOAD: begin
        state_next = pis_pkg::S_EMIT_HOLD;
      end
      pis_pkg::S_EMIT_HOLD: begin
        if (status.out_fire) begin
          state_next = status.k_end ? pis_pkg::S_COLLECT : pis_pkg::S_EMIT_RD;
        end
      end
      default: begin
        state_next = pis_pkg::S_COLLECT;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      pis_pkg::S_COLLECT:   cmd.collect   = 1'b1;
      pis_pkg::S_RD_I:      cmd.rd_i      = 1'b1;
      pis_pkg::S_EVAL_I:    cmd.eval_i    = 1'b1;
      pis_pkg::S_MOVE:      cmd.move      = 1'b1;
      pis_pkg::S_SHIFT:     cmd.shift     = 1'b1;
      pis_pkg::S_PLACE:     cmd.place     = 1'b1;
      pis_pkg::S_EMIT_RD:   cmd.emit_rd   = 1'b1;
      pis_pkg::S_EMIT_LOAD: cmd.emit_load = 1'b1;
      pis_pkg::S_EMIT_HOLD: cmd.emit_hold = 1'b1;
      default:              cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/pis_dp.sv -----
// Datapath of the partial insertion sort block: entry store, counters,
// threshold register, compares and the result register.
// Depends on pis_pkg, the channel interfaces and pis_ram.
`default_nettype none

module pis_dp #(
  parameter int MAX_ENTRIES = pis_pkg::MAX_ENTRIES
) (
  input  wire logic          clk,
  input  wire logic          rst,
  pis_entry_if.sink          entry,
  pis_result_if.source       result,
  pis_cfg_if.sink            cfg,
  input  wire pis_pkg::cmd_t cmd,
  output pis_pkg::status_t   status
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int WW = pis_pkg::WORD_W;
  localparam int SW = pis_pkg::SCORE_W;
  localparam int KW = pis_pkg::CODE_W;

  logic [CW-1:0]        count;
  logic                 overflow;
  logic signed [SW-1:0] thr;
  logic [AW-1:0]        i;
  logic [AW-1:0]        p;
  logic [AW-1:0]        j;
  logic [AW-1:0]        k;
  logic [WW-1:0]        held;
  logic [KW-1:0]        out_code;
  logic signed [SW-1:0] out_sc;
  logic                 out_last_r;
  logic                 out_ovf;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [WW-1:0]        wdata;
  logic [AW-1:0]        raddr;
  logic [WW-1:0]        rdata;

  logic                 full;
  logic                 in_fire;
  logic                 out_fire;
  logic                 hit;
  logic                 less;
  logic                 i_end;
  logic                 k_end;
  logic signed [SW-1:0] rd_score;
  logic signed [SW-1:0] held_score;

  pis_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign full       = (count == CW'(MAX_ENTRIES));
  assign entry.ready = cmd.collect;
  assign in_fire    = entry.valid & entry.ready;
  assign cfg.ready  = 1'b1;

  assign rd_score   = $signed(rdata[WW-1:KW]);
  assign held_score = $signed(held[WW-1:KW]);
  assign hit        = (rd_score >= thr);
  assign less       = (rd_score < held_score);
  assign i_end      = ((CW'(i) + CW'(1)) == count);
  assign k_end      = ((CW'(k) + CW'(1)) == count);

  assign result.valid         = cmd.emit_hold;
  assign result.out_move_code = out_code;
  assign result.out_score     = out_sc;
  assign result.out_last      = out_last_r;
  assign result.overflowed    = out_ovf;
  assign out_fire             = result.valid & result.ready;

  always_comb begin
    status           = '0;
    status.last_fire = in_fire & entry.last_entry;
    status.multi     = full ? (count > CW'(1)) : (count != '0);
    status.hit       = hit;
    status.less      = less;
    status.j_one     = (j == AW'(1));
    status.i_end     = i_end;
    status.out_fire  = out_fire;
    status.k_end     = k_end;
  end

  always_comb begin
    we    = 1'b0;
    waddr = count[AW-1:0];
    wdata = {entry.score, entry.move_code};
    raddr = i;
    if (cmd.collect) begin
      we = in_fire & ~full;
    end else if (cmd.rd_i) begin
      raddr = i;
    end else if (cmd.eval_i) begin
      raddr = p + AW'(1);
    end else if (cmd.move) begin
      we    = 1'b1;
      waddr = i;
      wdata = rdata;
      raddr = j - AW'(1);
    end else if (cmd.shift) begin
      we    = 1'b1;
      waddr = j;
      wdata = less ? rdata : held;
      raddr = j - AW'(2);
    end else if (cmd.place) begin
      we    = 1'b1;
      waddr = j;
      wdata = held;
    end else if (cmd.emit_rd) begin
      raddr = k;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
      thr      <= pis_pkg::THRESHOLD_RESET;
    end else begin
      if (cfg.valid & cfg.ready) begin
        thr <= cfg.score_threshold;
      end
      if (in_fire) begin
        if (full) begin
          overflow <= 1'b1;
        end else begin
          count <= count + CW'(1);
        end
      end
      if (out_fire & k_end) begin
        count    <= '0;
        overflow <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire & entry.last_entry) begin
      i <= AW'(1);
      p <= '0;
      k <= '0;
    end
    if (cmd.eval_i) begin
      if (hit) begin
        held <= rdata;
        p    <= p + AW'(1);
        j    <= p + AW'(1);
      end else begin
        i <= i + AW'(1);
      end
    end
    if (cmd.shift) begin
      if (less) begin
        j <= j - AW'(1);
      end else begin
        i <= i + AW'(1);
      end
    end
    if (cmd.place) begin
      i <= i + AW'(1);
    end
    if (cmd.emit_load) begin
      out_code   <= rdata[KW-1:0];
      out_sc     <= rd_score;
      out_last_r <= k_end;
      out_ovf    <= overflow;
    end
    if (out_fire & ~k_end) begin
      k <= k + AW'(1);
    end
  end

endmodule

`default_nettype wire

// ----- src/partial_insertion_sort.sv -----
// Top level of the partial insertion sort block: controller and datapath.
// Depends on pis_pkg, the channel interfaces, pis_ctrl and pis_dp.
//
// Items arrive on the entry channel, one per cycle while collecting, and are
// written to an entry store of MAX_ENTRIES words. Items beyond capacity are
// dropped and the list is marked as overflowed. Nothing is output until the
// item marked last arrives; then ready stays low while the list is sorted
// and emitted. Each stored entry after the first is read and then examined,
// and an entry at or above the threshold is then moved and shifted past
// each prefix entry of lower score, one step at a time, since every step
// goes through the single read port of the store. A list of one entry
// skips the sort. Each result is then read from the store, loaded into an
// output register and offered on the result channel, held there for as long
// as the receiver stalls; the next is read only after it is taken. The final
// item carries out_last. After the final item is taken, collection of the
// next list starts. The threshold register may be written at any cycle on
// the cfg channel and is meant to change only between lists. Reset returns
// the block to collecting with an empty list and a threshold of 200.
`default_nettype none

module partial_insertion_sort #(
  parameter int MAX_ENTRIES = pis_pkg::MAX_ENTRIES
) (
  input  wire logic    clk,
  input  wire logic    rst,
  pis_entry_if.sink    entry,
  pis_result_if.source result,
  pis_cfg_if.sink      cfg
);

  pis_pkg::cmd_t    cmd;
  pis_pkg::status_t status;

  pis_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  pis_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .entry  (entry),
    .result (result),
    .cfg    (cfg),
    .cmd    (cmd),
    .status (status)
  );

endmodule

`default_nettype wire
